// ===== rtl/abrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Beacon rate controller package
// Shared widths, codes, reset values and types for the beacon rate controller.
// ----------------------------------------------------------------------------
package abrc_pkg;

    localparam int FRAC_BITS   = 8;
    localparam int RATE_W      = 16;
    localparam int PERIOD_W    = 16;
    localparam int CNT_W       = 8;
    localparam int SEC_W       = 8;
    localparam int DECAY_W     = 8;
    localparam int DECAY_SHIFT = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int MUL_W       = 16;
    localparam int PROD_W      = 2 * MUL_W;

    localparam int CNT_TERM_W = CNT_W + FRAC_BITS;
    localparam int SUM_W      = ((CNT_TERM_W > RATE_W) ? CNT_TERM_W : RATE_W) + 1;
    localparam int SEC_TERM_W = SEC_W + FRAC_BITS;
    localparam int CMP_W      = (SEC_TERM_W > PERIOD_W) ? SEC_TERM_W : PERIOD_W;
    localparam int PADJ_W     = PROD_W - FRAC_BITS;

    localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST  = 16'd512;
    localparam logic [PERIOD_W-1:0] MAX_PERIOD_RST  = 16'd5120;
    localparam logic [DECAY_W-1:0]  DECAY_RST       = 8'd253;
    localparam logic [MUL_W-1:0]    GROW_RST        = 16'd320;
    localparam logic [MUL_W-1:0]    SHRINK_RST      = 16'd204;
    localparam logic [RATE_W-1:0]   HIGH_LIMIT_RST  = 16'd256;
    localparam logic [RATE_W-1:0]   LOW_LIMIT_RST   = 16'd186;
    localparam logic [RATE_W-1:0]   START_ACC_RST   = 16'd10922;
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd512;
    localparam logic [DECAY_W:0]    DECAY_ONE       = 9'd256;
    localparam logic [CNT_W-1:0]    CNT_MAX         = '1;
    localparam logic [SEC_W-1:0]    SEC_MAX         = '1;

    typedef enum logic [2:0] {
        MODE_START      = 3'd0,
        MODE_TICK       = 3'd1,
        MODE_HEARD      = 3'd2,
        MODE_SEND_DONE  = 3'd3,
        MODE_SET_ID     = 3'd4,
        MODE_CLEAR_ID   = 3'd5,
        MODE_WRITE_DONE = 3'd6,
        MODE_READ_DONE  = 3'd7
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PERIOD  = 3'd0,
        CFG_MAX_PERIOD  = 3'd1,
        CFG_DECAY       = 3'd2,
        CFG_GROW        = 3'd3,
        CFG_SHRINK      = 3'd4,
        CFG_HIGH_LIMIT  = 3'd5,
        CFG_LOW_LIMIT   = 3'd6,
        CFG_START_ACC   = 3'd7
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_DECAY,
        ST_ACCUM,
        ST_MUL_RATE,
        ST_COMPARE,
        ST_MUL_PERIOD,
        ST_CLAMP,
        ST_FINISH
    } seq_state_t;

    typedef enum logic [1:0] {
        ADJ_NONE,
        ADJ_GROW,
        ADJ_SHRINK
    } adj_t;

    typedef struct packed {
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } mul_operands_t;

endpackage

// ===== rtl/abrc_mul_unit.sv =====
// ----------------------------------------------------------------------------
// Beacon rate controller shared multiplier
// One 16x16 multiplier with a registered product, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module abrc_mul_unit (
    input  logic                        aclk,
    input  abrc_pkg::mul_operands_t     ops_i,
    output logic [abrc_pkg::PROD_W-1:0] prod_o
);
    import abrc_pkg::*;

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(ops_i.a) * PROD_W'(ops_i.b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod_o = prod_reg;

endmodule

// ===== rtl/adaptive_beacon_rate_controller_top.sv =====
// ----------------------------------------------------------------------------
// Adaptive beacon rate controller
// Event-driven beacon period control with a decaying message-rate estimate.
// ----------------------------------------------------------------------------
// One transaction on the input channel is one event and yields exactly one
// result transaction. Events are handled one at a time: s_ready is high only
// while the sequencer is idle. An event other than a tick goes straight to
// the final step; a tick first passes the decay multiply and accumulate
// steps and, when the broadcast period is reached, the rate multiply,
// compare, period multiply and clamp steps, since all three products
// (accumulator decay, measured rate and period adjustment) go through one
// shared registered 16x16 multiplier in turn. A result that is not taken
// holds the sequencer in its final step; ready returns once it is registered.
// ----------------------------------------------------------------------------
module adaptive_beacon_rate_controller_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [abrc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [abrc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [2:0]                        s_mode,
    input  logic                              s_send_ok,
    input  logic                              s_buffer_is_ours,
    input  logic                              s_read_success,
    input  logic                              s_stored_valid,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_send_request,
    output logic [abrc_pkg::RATE_W-1:0]       m_report_rate,
    output logic [abrc_pkg::PERIOD_W-1:0]     m_report_period,
    output logic                              m_store_write,
    output logic                              m_store_flag,
    output logic                              m_identity_valid,
    output logic                              m_identity_taken,
    output logic                              m_buffer_released
);
    import abrc_pkg::*;

    typedef struct packed {
        logic pending;
        logic busy;
        logic write;
        logic flag;
    } save_t;

    function automatic save_t try_save(input logic busy, input logic have);
        save_t s;
        if (busy) begin
            s = '{pending: 1'b1, busy: 1'b1, write: 1'b0, flag: 1'b0};
        end else begin
            s = '{pending: 1'b0, busy: 1'b1, write: 1'b1, flag: have};
        end
        return s;
    endfunction

    // configuration
    logic [PERIOD_W-1:0] min_period_reg, max_period_reg;
    logic [DECAY_W-1:0]  decay_reg;
    logic [MUL_W-1:0]    grow_reg, shrink_reg;
    logic [RATE_W-1:0]   high_limit_reg, low_limit_reg, start_acc_reg;

    // block state
    seq_state_t          state_reg, state_next;
    logic [RATE_W-1:0]   acc_reg, acc_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    logic                send_pending_reg, send_pending_next;
    logic                have_id_reg, have_id_next;
    logic                store_busy_reg, store_busy_next;
    logic                save_pending_reg, save_pending_next;
    logic                send_ok_reg, send_ok_next;
    adj_t                adj_reg, adj_next;
    logic                req_reg, req_next;
    logic                taken_reg, taken_next;
    logic                released_reg, released_next;
    logic                wr_reg, wr_next;
    logic                flag_reg, flag_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic                m_send_request_reg;
    logic [RATE_W-1:0]   m_report_rate_reg;
    logic [PERIOD_W-1:0] m_report_period_reg;
    logic                m_store_write_reg, m_store_flag_reg;
    logic                m_identity_valid_reg, m_identity_taken_reg;
    logic                m_buffer_released_reg;

    mul_operands_t       mul_ops;
    logic [PROD_W-1:0]   prod;
    mode_t               mode;
    logic                accept;
    logic                out_free;
    logic                out_load;
    logic [SUM_W-1:0]    acc_sum;
    logic [RATE_W-1:0]   acc_sat;
    logic [SEC_W-1:0]    sec_inc;
    logic                reached;
    logic [RATE_W-1:0]   rate;
    logic [PADJ_W-1:0]   p_full;
    logic [DECAY_W:0]    decay_comp;
    save_t               save;

    abrc_mul_unit u_mul (
        .aclk   (aclk),
        .ops_i  (mul_ops),
        .prod_o (prod)
    );

    assign mode     = mode_t'(s_mode);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign acc_sum = SUM_W'(prod[DECAY_SHIFT+RATE_W-1:DECAY_SHIFT])
                   + SUM_W'({count_reg, {FRAC_BITS{1'b0}}});
    assign acc_sat = (|acc_sum[SUM_W-1:RATE_W]) ? '1 : acc_sum[RATE_W-1:0];
    assign sec_inc = (sec_reg == SEC_MAX) ? sec_reg : sec_reg + 1'b1;
    assign reached = CMP_W'({sec_inc, {FRAC_BITS{1'b0}}}) >= CMP_W'(period_reg);
    assign rate    = prod[DECAY_SHIFT+RATE_W-1:DECAY_SHIFT];
    assign p_full  = (adj_reg == ADJ_NONE) ? PADJ_W'(period_reg)
                                           : prod[PROD_W-1:FRAC_BITS];
    assign decay_comp = DECAY_ONE - (DECAY_W+1)'(decay_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (mode == MODE_TICK) ? ST_MUL_DECAY : ST_FINISH;
                end
            end
            ST_MUL_DECAY:  state_next = ST_ACCUM;
            ST_ACCUM:      state_next = reached ? ST_MUL_RATE : ST_FINISH;
            ST_MUL_RATE:   state_next = ST_COMPARE;
            ST_COMPARE:    state_next = ST_MUL_PERIOD;
            ST_MUL_PERIOD: state_next = ST_CLAMP;
            ST_CLAMP:      state_next = ST_FINISH;
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:       state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs and datapath
    always_comb begin
        s_ready           = 1'b0;
        out_load          = 1'b0;
        mul_ops           = '{a: acc_reg, b: MUL_W'(decay_reg)};
        acc_next          = acc_reg;
        count_next        = count_reg;
        period_next       = period_reg;
        sec_next          = sec_reg;
        send_pending_next = send_pending_reg;
        have_id_next      = have_id_reg;
        store_busy_next   = store_busy_reg;
        save_pending_next = save_pending_reg;
        send_ok_next      = send_ok_reg;
        adj_next          = adj_reg;
        req_next          = req_reg;
        taken_next        = taken_reg;
        released_next     = released_reg;
        wr_next           = wr_reg;
        flag_next         = flag_reg;
        save              = '0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    send_ok_next  = s_send_ok;
                    req_next      = 1'b0;
                    taken_next    = 1'b0;
                    released_next = 1'b0;
                    wr_next       = 1'b0;
                    flag_next     = 1'b0;
                    case (mode)
                        MODE_START: begin
                            send_pending_next = 1'b0;
                            period_next       = min_period_reg;
                            acc_next          = start_acc_reg;
                            count_next        = '0;
                        end
                        MODE_TICK: begin
                        end
                        MODE_HEARD: begin
                            if (count_reg != CNT_MAX) begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_SEND_DONE: begin
                            if (send_pending_reg && s_buffer_is_ours) begin
                                send_pending_next = 1'b0;
                                released_next     = 1'b1;
                            end
                        end
                        MODE_SET_ID: begin
                            if (!have_id_reg) begin
                                have_id_next      = 1'b1;
                                taken_next        = 1'b1;
                                save              = try_save(store_busy_reg, 1'b1);
                                save_pending_next = save.pending;
                                store_busy_next   = save.busy;
                                wr_next           = save.write;
                                flag_next         = save.flag;
                            end
                        end
                        MODE_CLEAR_ID: begin
                            have_id_next      = 1'b0;
                            save              = try_save(store_busy_reg, 1'b0);
                            save_pending_next = save.pending;
                            store_busy_next   = save.busy;
                            wr_next           = save.write;
                            flag_next         = save.flag;
                        end
                        MODE_WRITE_DONE: begin
                            store_busy_next = 1'b0;
                            if (save_pending_reg) begin
                                save              = try_save(1'b0, have_id_reg);
                                save_pending_next = save.pending;
                                store_busy_next   = save.busy;
                                wr_next           = save.write;
                                flag_next         = save.flag;
                            end
                        end
                        MODE_READ_DONE: begin
                            if (s_read_success) begin
                                have_id_next = s_stored_valid;
                            end
                            save_pending_next = 1'b0;
                            store_busy_next   = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL_DECAY: begin
                mul_ops = '{a: acc_reg, b: MUL_W'(decay_reg)};
            end
            ST_ACCUM: begin
                acc_next   = acc_sat;
                count_next = '0;
                sec_next   = reached ? '0 : sec_inc;
            end
            ST_MUL_RATE: begin
                mul_ops = '{a: acc_reg, b: MUL_W'(decay_comp)};
            end
            ST_COMPARE: begin
                if (rate > high_limit_reg) begin
                    adj_next = ADJ_GROW;
                end else if (rate < low_limit_reg) begin
                    adj_next = ADJ_SHRINK;
                end else begin
                    adj_next = ADJ_NONE;
                end
            end
            ST_MUL_PERIOD: begin
                mul_ops = '{a: period_reg,
                            b: (adj_reg == ADJ_SHRINK) ? shrink_reg : grow_reg};
            end
            ST_CLAMP: begin
                if (p_full < PADJ_W'(min_period_reg)) begin
                    period_next = min_period_reg;
                end else if (p_full > PADJ_W'(max_period_reg)) begin
                    period_next = max_period_reg;
                end else begin
                    period_next = p_full[PERIOD_W-1:0];
                end
                if (have_id_reg && !send_pending_reg) begin
                    req_next = 1'b1;
                    if (send_ok_reg) begin
                        send_pending_next = 1'b1;
                        if (count_reg != CNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
            end
            ST_FINISH: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_period_reg <= MIN_PERIOD_RST;
            max_period_reg <= MAX_PERIOD_RST;
            decay_reg      <= DECAY_RST;
            grow_reg       <= GROW_RST;
            shrink_reg     <= SHRINK_RST;
            high_limit_reg <= HIGH_LIMIT_RST;
            low_limit_reg  <= LOW_LIMIT_RST;
            start_acc_reg  <= START_ACC_RST;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_PERIOD: min_period_reg <= cfg_wdata;
                CFG_MAX_PERIOD: max_period_reg <= cfg_wdata;
                CFG_DECAY:      decay_reg      <= cfg_wdata[DECAY_W-1:0];
                CFG_GROW:       grow_reg       <= cfg_wdata;
                CFG_SHRINK:     shrink_reg     <= cfg_wdata;
                CFG_HIGH_LIMIT: high_limit_reg <= cfg_wdata;
                CFG_LOW_LIMIT:  low_limit_reg  <= cfg_wdata;
                CFG_START_ACC:  start_acc_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            acc_reg          <= '0;
            count_reg        <= '0;
            period_reg       <= PERIOD_RST;
            sec_reg          <= '0;
            send_pending_reg <= 1'b0;
            have_id_reg      <= 1'b0;
            store_busy_reg   <= 1'b1;
            save_pending_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            acc_reg          <= acc_next;
            count_reg        <= count_next;
            period_reg       <= period_next;
            sec_reg          <= sec_next;
            send_pending_reg <= send_pending_next;
            have_id_reg      <= have_id_next;
            store_busy_reg   <= store_busy_next;
            save_pending_reg <= save_pending_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        send_ok_reg  <= send_ok_next;
        adj_reg      <= adj_next;
        req_reg      <= req_next;
        taken_reg    <= taken_next;
        released_reg <= released_next;
        wr_reg       <= wr_next;
        flag_reg     <= flag_next;
        if (out_load) begin
            m_send_request_reg    <= req_reg;
            m_report_rate_reg     <= acc_reg;
            m_report_period_reg   <= period_reg;
            m_store_write_reg     <= wr_reg;
            m_store_flag_reg      <= flag_reg;
            m_identity_valid_reg  <= have_id_reg;
            m_identity_taken_reg  <= taken_reg;
            m_buffer_released_reg <= released_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_send_request    = m_send_request_reg;
    assign m_report_rate     = m_report_rate_reg;
    assign m_report_period   = m_report_period_reg;
    assign m_store_write     = m_store_write_reg;
    assign m_store_flag      = m_store_flag_reg;
    assign m_identity_valid  = m_identity_valid_reg;
    assign m_identity_taken  = m_identity_taken_reg;
    assign m_buffer_released = m_buffer_released_reg;

endmodule

// ===== rtl/abrc_checker.sv =====
// ----------------------------------------------------------------------------
// Beacon rate controller port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module abrc_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_send_request,
    input logic [abrc_pkg::RATE_W-1:0]       m_report_rate,
    input logic [abrc_pkg::PERIOD_W-1:0]     m_report_period,
    input logic                              m_store_write,
    input logic                              m_store_flag,
    input logic                              m_identity_valid,
    input logic                              m_identity_taken,
    input logic                              m_buffer_released
);
    import abrc_pkg::*;

    // hold a stalled result transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_report_rate)
                                && $stable(m_report_period))
        else $error("stalled result transaction changed");

    // one event at a time: busy after every accepted transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an event is in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_identity_taken |-> m_identity_valid)
        else $error("identity taken without identity held");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_store_flag |-> m_store_write)
        else $error("store flag without store write");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_send_request && m_buffer_released))
        else $error("send request and buffer release in one result");

endmodule

bind adaptive_beacon_rate_controller_top abrc_checker u_abrc_checker (.*);
